@@ design/kne_pkg.sv @@
// Shared types and constants for the keyed number field extractor.
package kne_pkg;

    // Result outcome codes
    typedef enum logic [1:0] {
        OC_OK        = 2'd0,
        OC_NOT_FOUND = 2'd1,
        OC_NO_DIGITS = 2'd2,
        OC_OVERFLOW  = 2'd3
    } t_outcome;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

    localparam int KEY_TEXT_W = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int VALUE_W    = 32;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

endpackage

@@ design/keyed_number_field_extractor.sv @@
// Keyed number field extractor: key search and number parse over a byte stream.
// The block takes one text byte per cycle, with no gaps between buffers. A byte is
// registered on acceptance, and from that input stage the scan state is updated and,
// for the final byte of a buffer, the result register and its valid flag are loaded.
// The rate is set by the scan update: one window compare against the key and one
// multiply-by-base accumulate. Only a result held by a stalled output can stall the
// input, and then only once the final byte of the next buffer reaches the scan stage.
module keyed_number_field_extractor #(
    parameter int KEY_MAX_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kne_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kne_pkg::KEY_TEXT_W-1:0]    i_cfg_data,
    // byte input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_text_byte,
    input  logic                              i_end_of_buffer,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_outcome,
    output logic [kne_pkg::VALUE_W-1:0]       o_number_value
);

    localparam int WW = 8 * KEY_MAX_BYTES;
    localparam int KW = $clog2(KEY_MAX_BYTES + 1);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_SKIP   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_ZERO_X = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // configuration registers
    logic [WW-1:0]                 r_key_text;
    logic [kne_pkg::KEY_LEN_W-1:0] r_key_len;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // scan state
    t_phase                      r_phase, n_phase;
    logic [WW-1:0]               r_win, n_win;
    logic [KW-1:0]               r_seen, n_seen;
    logic                        r_hex, n_hex;
    logic [kne_pkg::VALUE_W-1:0] r_acc, n_acc;
    kne_pkg::t_outcome           r_held, n_held;

    // result register
    logic                        r_out_valid;
    kne_pkg::t_outcome           r_outcome, n_outcome;
    logic [kne_pkg::VALUE_W-1:0] r_value, n_value;

    logic                          advance;
    logic [KW-1:0]                 eff_len;
    logic [WW-1:0]                 win_shift;
    logic [KEY_MAX_BYTES-1:0]      len_match;
    logic [KEY_MAX_BYTES-1:0]      len_sel;
    logic                          key_hit;
    logic                          is_blank;
    logic                          dig_ok;
    logic [3:0]                    dig_val;
    logic [kne_pkg::VALUE_W+3:0]   mac;

    // Digit decode: valid flag and value for the current base
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [4:0] res;
        res = 5'd0;
        if (c >= kne_pkg::CH_ZERO && c <= kne_pkg::CH_NINE) begin
            res = {1'b1, 4'(c - kne_pkg::CH_ZERO)};
        end else if (hex && c >= kne_pkg::CH_LO_A && c <= kne_pkg::CH_LO_F) begin
            res = {1'b1, 4'(c - kne_pkg::CH_LO_A + 8'd10)};
        end else if (hex && c >= kne_pkg::CH_UP_A && c <= kne_pkg::CH_UP_F) begin
            res = {1'b1, 4'(c - kne_pkg::CH_UP_A + 8'd10)};
        end
        return res;
    endfunction

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid & (~r_last | ~r_out_valid | ~i_out_stall);
    assign o_stall     = r_in_valid & ~advance;

    // Effective key length, clamped to 1..KEY_MAX_BYTES
    always_comb begin
        if (r_key_len == '0) begin
            eff_len = KW'(1);
        end else if (r_key_len > kne_pkg::KEY_LEN_W'(KEY_MAX_BYTES)) begin
            eff_len = KW'(KEY_MAX_BYTES);
        end else begin
            eff_len = KW'(r_key_len);
        end
    end

    // Window shift and key compare, one comparator per possible key length
    assign win_shift = (r_win >> 8) | (WW'(r_byte) << (8 * (KEY_MAX_BYTES - 1)));

    always_comb begin
        logic [WW-1:0] shifted;
        logic [WW-1:0] msk;
        for (int j = 1; j <= KEY_MAX_BYTES; j++) begin
            shifted = win_shift >> (8 * (KEY_MAX_BYTES - j));
            msk     = '0;
            for (int b = 0; b < j; b++) begin
                msk[8*b +: 8] = 8'hFF;
            end
            len_match[j-1] = (((shifted ^ r_key_text) & msk) == '0);
            len_sel[j-1]   = (eff_len == KW'(j));
        end
    end

    assign key_hit = |(len_match & len_sel);

    assign is_blank = (r_byte == kne_pkg::CH_SPACE) || (r_byte == kne_pkg::CH_TAB) ||
                      (r_byte == kne_pkg::CH_CR)    || (r_byte == kne_pkg::CH_LF)  ||
                      (r_byte == kne_pkg::CH_COLON);

    // Digit decode; prefix-x stage always decodes in hex
    always_comb begin
        logic [4:0] d;
        d       = digit_of(r_byte, r_hex | (r_phase == PH_ZERO_X));
        dig_ok  = d[4];
        dig_val = d[3:0];
    end

    // Multiply-accumulate by the base, with room to spot overflow
    assign mac = r_hex ? (({4'd0, r_acc} << 4) + (kne_pkg::VALUE_W+4)'(dig_val))
                       : (({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                          + (kne_pkg::VALUE_W+4)'(dig_val));

    // Scan state update
    always_comb begin
        n_phase = r_phase;
        n_win   = r_win;
        n_seen  = r_seen;
        n_hex   = r_hex;
        n_acc   = r_acc;
        n_held  = r_held;
        unique case (r_phase)
            PH_SEARCH: begin
                n_win = win_shift;
                if (r_seen < KW'(KEY_MAX_BYTES)) begin
                    n_seen = r_seen + KW'(1);
                end
                if (n_seen >= eff_len && !r_last && key_hit) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (!is_blank) begin
                    n_hex = 1'b0;
                    if (r_byte == kne_pkg::CH_ZERO) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (dig_ok) begin
                        n_acc   = kne_pkg::VALUE_W'(dig_val);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_held  = kne_pkg::OC_NO_DIGITS;
                        n_acc   = '0;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_ZERO: begin
                if (r_byte == kne_pkg::CH_LO_X || r_byte == kne_pkg::CH_UP_X) begin
                    if (r_last) begin
                        n_held  = kne_pkg::OC_OK;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_ZERO_X;
                    end
                end else if (dig_ok) begin
                    n_acc   = kne_pkg::VALUE_W'(dig_val);
                    n_phase = PH_DIGITS;
                end else begin
                    n_held  = kne_pkg::OC_OK;
                    n_phase = PH_DONE;
                end
            end
            PH_ZERO_X: begin
                n_hex = 1'b1;
                if (dig_ok) begin
                    n_acc   = kne_pkg::VALUE_W'(dig_val);
                    n_phase = PH_DIGITS;
                end else begin
                    n_held  = kne_pkg::OC_NO_DIGITS;
                    n_acc   = '0;
                    n_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (!dig_ok) begin
                    n_held  = kne_pkg::OC_OK;
                    n_phase = PH_DONE;
                end else if (mac[kne_pkg::VALUE_W+3:kne_pkg::VALUE_W] != 4'd0) begin
                    n_held  = kne_pkg::OC_OVERFLOW;
                    n_acc   = '0;
                    n_phase = PH_DONE;
                end else begin
                    n_acc = mac[kne_pkg::VALUE_W-1:0];
                end
            end
            default: begin
                // outcome already decided: ignore the rest of the buffer
            end
        endcase
    end

    // Result from the updated scan state
    always_comb begin
        n_value = '0;
        unique case (n_phase)
            PH_SEARCH: n_outcome = kne_pkg::OC_NOT_FOUND;
            PH_SKIP:   n_outcome = kne_pkg::OC_NO_DIGITS;
            PH_ZERO:   n_outcome = kne_pkg::OC_OK;
            PH_ZERO_X: n_outcome = kne_pkg::OC_NO_DIGITS;
            PH_DIGITS: begin
                n_outcome = kne_pkg::OC_OK;
                n_value   = n_acc;
            end
            default: begin
                n_outcome = n_held;
                if (n_held == kne_pkg::OC_OK) begin
                    n_value = n_acc;
                end
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_text <= '0;
            r_key_len  <= kne_pkg::KEY_LEN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kne_pkg::CFG_KEY_TEXT:   r_key_text <= i_cfg_data[WW-1:0];
                kne_pkg::CFG_KEY_LENGTH: r_key_len  <= i_cfg_data[kne_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_byte <= i_text_byte;
            r_last <= i_end_of_buffer;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_outcome <= n_outcome;
            r_value   <= n_value;
        end
    end

    // Control state: input valid, scan state, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_SEARCH;
            r_win       <= '0;
            r_seen      <= '0;
            r_hex       <= 1'b0;
            r_acc       <= '0;
            r_held      <= kne_pkg::OC_NOT_FOUND;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                if (r_last) begin
                    // buffer finished: clear the scan
                    r_phase <= PH_SEARCH;
                    r_win   <= '0;
                    r_seen  <= '0;
                    r_hex   <= 1'b0;
                    r_acc   <= '0;
                    r_held  <= kne_pkg::OC_NOT_FOUND;
                end else begin
                    r_phase <= n_phase;
                    r_win   <= n_win;
                    r_seen  <= n_seen;
                    r_hex   <= n_hex;
                    r_acc   <= n_acc;
                    r_held  <= n_held;
                end
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_number_value = r_value;

    // A stall toward the source only comes from a final byte blocked by a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // Only an ok outcome carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome != kne_pkg::OC_OK) |-> (o_number_value == '0))
        else $error("non-ok result carries a value");

    // The scan restarts clean after a buffer's final byte
    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> (r_phase == PH_SEARCH && r_seen == '0 && r_acc == '0))
        else $error("scan state not cleared after final byte");

    // Byte count saturates at the key capacity
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= KW'(KEY_MAX_BYTES))
        else $error("byte count beyond key capacity");

endmodule

@@ dv/keyed_number_field_extractor_test.sv @@
// Self-checking testbench for the keyed number field extractor.
module keyed_number_field_extractor_test;

    localparam int CLK_PERIOD     = 12;
    localparam int KEY_MAX        = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int ITEM_TARGET    = 1300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef enum logic [2:0] {
        SCAN_FIND,
        SCAN_SKIP,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan_phase;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } t_text_item;

    typedef struct packed {
        kne_pkg::t_outcome             outcome;
        logic [kne_pkg::VALUE_W-1:0]   value;
    } t_field_result;

    // DUT signals
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [kne_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [kne_pkg::KEY_TEXT_W-1:0]  i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [7:0]                      i_text_byte = '0;
    logic                            i_end_of_buffer = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [1:0]                      o_outcome;
    logic [kne_pkg::VALUE_W-1:0]     o_number_value;

    // Bytes waiting to be offered, and parse results waiting to arrive
    t_text_item     pending_bytes[$];
    t_field_result  expected_fields[$];
    int unsigned    byte_count = 0;
    int unsigned    error_count = 0;

    // Predictor state and its copy of the registers
    logic [63:0]                     win_bytes;
    int unsigned                     seen_count;
    t_scan_phase                     scan_state;
    logic                            hex_digits;
    logic [kne_pkg::VALUE_W-1:0]     acc_value;
    kne_pkg::t_outcome               held_code;
    logic [kne_pkg::KEY_TEXT_W-1:0]  cfg_key_text;
    logic [kne_pkg::KEY_LEN_W-1:0]   cfg_key_len;

    // Stimulus side view of the key in use
    logic [63:0]    gen_key_text;
    int unsigned    gen_key_len;
    logic [7:0]     draft[$];

    // Receiver hold-off control
    logic           hold_req = 1'b0;
    logic           hold_taken;
    int unsigned    hold_left;
    t_stall_mode    stall_mode;
    int unsigned    mode_left;
    logic [31:0]    tick;

    // Sender burst control
    int unsigned    burst_left;
    int unsigned    gap_left;

    keyed_number_field_extractor #(
        .KEY_MAX_BYTES(KEY_MAX)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_text_byte     (i_text_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_outcome       (o_outcome),
        .o_number_value  (o_number_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    // Out-of-range lengths clamp to 1..KEY_MAX
    function automatic int unsigned active_key_len(logic [kne_pkg::KEY_LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > KEY_MAX) return KEY_MAX;
        return 32'(len);
    endfunction

    // Digit weight in the current base; 16 means not a digit
    function automatic int unsigned digit_value(logic [7:0] c, logic in_hex);
        if (c >= kne_pkg::CH_ZERO && c <= kne_pkg::CH_NINE)
            return 32'(c - kne_pkg::CH_ZERO);
        if (in_hex && c >= kne_pkg::CH_LO_A && c <= kne_pkg::CH_LO_F)
            return 10 + 32'(c - kne_pkg::CH_LO_A);
        if (in_hex && c >= kne_pkg::CH_UP_A && c <= kne_pkg::CH_UP_F)
            return 10 + 32'(c - kne_pkg::CH_UP_A);
        return 16;
    endfunction

    task automatic restart_scan();
        win_bytes  = '0;
        seen_count = 0;
        scan_state = SCAN_FIND;
        hex_digits = 1'b0;
        acc_value  = '0;
        held_code  = kne_pkg::OC_NOT_FOUND;
    endtask

    task automatic settle_outcome(input kne_pkg::t_outcome code);
        held_code = code;
        if (code != kne_pkg::OC_OK) acc_value = '0;
        scan_state = SCAN_DONE;
    endtask

    task automatic start_number(input logic [7:0] c, input kne_pkg::t_outcome fail_code);
        int unsigned d;
        d = digit_value(c, hex_digits);
        if (d < 16) begin
            acc_value  = d;
            scan_state = SCAN_DIGITS;
        end else begin
            settle_outcome(fail_code);
        end
    endtask

    // Advance the parse by one byte; a result comes out on the last byte
    task automatic scan_byte(input logic [7:0] c, input logic last,
                             output logic got, output t_field_result res);
        int unsigned k;
        int unsigned d;
        logic [63:0] key_mask;
        logic [63:0] wide;
        k   = active_key_len(cfg_key_len);
        got = 1'b0;
        res = '0;
        case (scan_state)
            SCAN_FIND: begin
                key_mask  = (k >= 8) ? {64{1'b1}} : ((64'd1 << (8 * k)) - 64'd1);
                win_bytes = {c, win_bytes[63:8]};
                if (seen_count < KEY_MAX) seen_count++;
                if (seen_count >= k && !last &&
                    (win_bytes >> (64 - 8 * k)) == (cfg_key_text & key_mask))
                    scan_state = SCAN_SKIP;
            end
            SCAN_SKIP: begin
                if (!(c inside {kne_pkg::CH_SPACE, kne_pkg::CH_TAB, kne_pkg::CH_CR,
                                kne_pkg::CH_LF, kne_pkg::CH_COLON})) begin
                    hex_digits = 1'b0;
                    if (c == kne_pkg::CH_ZERO) begin
                        acc_value  = '0;
                        scan_state = SCAN_ZERO;
                    end else begin
                        start_number(c, kne_pkg::OC_NO_DIGITS);
                    end
                end
            end
            SCAN_ZERO: begin
                if (c == kne_pkg::CH_LO_X || c == kne_pkg::CH_UP_X) begin
                    if (last) settle_outcome(kne_pkg::OC_OK);
                    else scan_state = SCAN_PREFIX;
                end else begin
                    start_number(c, kne_pkg::OC_OK);
                end
            end
            SCAN_PREFIX: begin
                hex_digits = 1'b1;
                start_number(c, kne_pkg::OC_NO_DIGITS);
            end
            SCAN_DIGITS: begin
                d = digit_value(c, hex_digits);
                if (d < 16) begin
                    wide = {32'd0, acc_value} * (hex_digits ? 64'd16 : 64'd10) + 64'(d);
                    if (wide > 64'hFFFF_FFFF) settle_outcome(kne_pkg::OC_OVERFLOW);
                    else acc_value = wide[31:0];
                end else begin
                    settle_outcome(kne_pkg::OC_OK);
                end
            end
            default: ;
        endcase
        if (last) begin
            got = 1'b1;
            case (scan_state)
                SCAN_FIND:               res.outcome = kne_pkg::OC_NOT_FOUND;
                SCAN_SKIP, SCAN_PREFIX:  res.outcome = kne_pkg::OC_NO_DIGITS;
                SCAN_ZERO:               res.outcome = kne_pkg::OC_OK;
                SCAN_DIGITS: begin
                    res.outcome = kne_pkg::OC_OK;
                    res.value   = acc_value;
                end
                default: begin
                    res.outcome = held_code;
                    if (held_code == kne_pkg::OC_OK) res.value = acc_value;
                end
            endcase
            restart_scan();
        end
    endtask

    // ---------------------------------------------------------------- driver

    // Byte sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : byte_driver
        t_text_item nxt;
        if (!i_rst_n) begin
            i_valid         <= 1'b0;
            i_text_byte     <= '0;
            i_end_of_buffer <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                nxt = pending_bytes.pop_front();
                i_valid         <= 1'b1;
                i_text_byte     <= nxt.text;
                i_end_of_buffer <= nxt.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        1:       gap_left <= $urandom_range(1, 3);
                        2:       gap_left <= $urandom_range(4, 20);
                        default: gap_left <= 0;
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver stall: changing patterns plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_taken  <= 1'b0;
            hold_left   <= 0;
            stall_mode  <= STALL_NONE;
            mode_left   <= 0;
            tick        <= '0;
        end else begin
            tick <= tick + 1;
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode <= t_stall_mode'($urandom_range(0, 3));
                    mode_left  <= $urandom_range(20, 200);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= (tick[1:0] == 2'b00);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Tracks register writes and accepted bytes, checks each result transaction
    always @(posedge i_clk) begin : result_monitor
        logic           got;
        t_field_result  res;
        t_field_result  want;
        if (!i_rst_n) begin
            cfg_key_text = '0;
            cfg_key_len  = kne_pkg::KEY_LEN_W'(1);
            restart_scan();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == kne_pkg::CFG_KEY_TEXT) cfg_key_text = i_cfg_data;
                else cfg_key_len = i_cfg_data[kne_pkg::KEY_LEN_W-1:0];
            end
            if (i_valid && !o_stall) begin
                scan_byte(i_text_byte, i_end_of_buffer, got, res);
                if (got) expected_fields.push_back(res);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_fields.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual outcome %0d value %0h",
                             $time, o_outcome, o_number_value);
                end else begin
                    want = expected_fields.pop_front();
                    if (o_outcome !== want.outcome) begin
                        error_count++;
                        $display("%0t: outcome mismatch: expected %0d, actual %0d",
                                 $time, want.outcome, o_outcome);
                    end
                    if (o_number_value !== want.value) begin
                        error_count++;
                        $display("%0t: number_value mismatch: expected %0h, actual %0h",
                                 $time, want.value, o_number_value);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Both registers back to back; valid stays high across the two transactions
    task automatic set_key(input logic [63:0] text, input logic [63:0] len_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= kne_pkg::CFG_KEY_TEXT;
        i_cfg_data  <= text;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= kne_pkg::CFG_KEY_LENGTH;
        i_cfg_data  <= len_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gen_key_text = text;
        gen_key_len  = active_key_len(len_data[kne_pkg::KEY_LEN_W-1:0]);
    endtask

    // Wait until every byte is taken and every result has arrived, then let it settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_fields.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endtask

    task automatic add_key();
        for (int i = 0; i < gen_key_len; i++) draft.push_back(gen_key_text[8 * i +: 8]);
    endtask

    task automatic add_separators(input int unsigned n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0:       draft.push_back(kne_pkg::CH_SPACE);
                1:       draft.push_back(kne_pkg::CH_TAB);
                2:       draft.push_back(kne_pkg::CH_CR);
                3:       draft.push_back(kne_pkg::CH_LF);
                default: draft.push_back(kne_pkg::CH_COLON);
            endcase
        end
    endtask

    task automatic add_noise(input int unsigned n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0:       draft.push_back(8'($urandom_range(0, 255)));
                1:       draft.push_back(8'($urandom_range(8'h61, 8'h7A)));
                2:       draft.push_back(8'($urandom_range(kne_pkg::CH_ZERO, kne_pkg::CH_NINE)));
                3:       draft.push_back(gen_key_text[7:0]);
                default: add_separators(1);
            endcase
        end
    endtask

    // Decimal or 0x/0X hex, from tiny values up past 32 bits
    task automatic add_number();
        logic [63:0] v;
        string       digits;
        case ($urandom_range(0, 6))
            0:       v = 64'($urandom_range(0, 9));
            1:       v = 64'($urandom_range(0, 99999));
            2:       v = 64'($urandom);
            3:       v = 64'hFFFF_FFFF - $urandom_range(0, 3);
            4:       v = 64'h1_0000_0000 + $urandom_range(0, 2);
            5:       v = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
            default: v = '0;
        endcase
        if ($urandom_range(0, 4) < 2) begin
            if ($urandom_range(0, 1)) add_text("0x");
            else add_text("0X");
            digits = $sformatf("%0h", v);
            if ($urandom_range(0, 1)) digits = digits.toupper();
        end else begin
            digits = $sformatf("%0d", v);
        end
        if ($urandom_range(0, 7) == 0) add_text("00");
        add_text(digits);
    endtask

    // Move the draft into the byte queue, marking its final byte
    task automatic commit_draft();
        if (draft.size() == 0) draft.push_back(8'($urandom_range(0, 255)));
        foreach (draft[i]) pending_bytes.push_back('{draft[i], i == draft.size() - 1});
        byte_count += draft.size();
        draft.delete();
    endtask

    // Mostly well-formed key/number buffers, the rest noise and truncations
    task automatic make_buffer();
        if ($urandom_range(0, 9) < 7) begin
            add_noise($urandom_range(0, 6));
            add_key();
            add_separators($urandom_range(0, 3));
            add_number();
            if ($urandom_range(0, 1)) add_noise($urandom_range(1, 4));
        end else begin
            case ($urandom_range(0, 6))
                0: add_noise($urandom_range(1, 10));
                1: begin
                    add_noise($urandom_range(0, 3));
                    add_key();
                end
                2: begin
                    add_key();
                    add_separators($urandom_range(1, 3));
                end
                3: begin
                    add_key();
                    add_separators($urandom_range(0, 2));
                    if ($urandom_range(0, 1)) add_text("0x");
                    else add_text("0X");
                end
                4: begin
                    add_key();
                    add_text("0x");
                    draft.push_back(8'($urandom_range(8'h67, 8'h7A)));
                    add_noise($urandom_range(0, 3));
                end
                5: begin
                    add_key();
                    draft.push_back(8'($urandom_range(0, 255)));
                    add_noise($urandom_range(0, 3));
                end
                default: begin
                    add_key();
                    add_text("0");
                end
            endcase
        end
        commit_draft();
    endtask

    // Register settings per phase: extremes first, then random
    task automatic program_key(input int unsigned phase_no);
        logic [63:0] text;
        logic [63:0] len_data;
        logic [3:0]  len_code;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 3) != 0) text[8 * i +: 8] = 8'($urandom_range(8'h41, 8'h7A));
            else text[8 * i +: 8] = 8'($urandom_range(0, 255));
        end
        case (phase_no)
            0: begin
                len_code = 4'd8;
                text     = {64{1'b1}};
            end
            1: len_code = 4'd15;
            2: begin
                len_code = 4'd9;
                text     = '0;
            end
            3: len_code = 4'd1;
            4: len_code = 4'd0;
            default: len_code = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(1, 8));
        endcase
        len_data      = {$urandom, $urandom};
        len_data[3:0] = len_code;
        set_key(text, len_data);
    endtask

    initial begin : stimulus
        int unsigned phase_no;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte key "k" with length code zero, junk in unused key bytes
        set_key({$urandom, 24'($urandom), 8'h6B}, 64'd0);
        add_text("k");            commit_draft();   // key on final byte
        add_text("k\t:");         commit_draft();   // ends while skipping
        add_text("k0X");          commit_draft();   // ends right after prefix
        add_text("k0xg");         commit_draft();   // prefix then non-hex
        add_text("k7a9");         commit_draft();   // stops at non-digit, rest ignored
        add_text("k4294967296");  commit_draft();   // just above 32 bits
        wait_drained();

        // Backpressure: many tiny buffers while the receiver holds off
        program_key(3);
        hold_req = 1'b1;
        repeat (100) begin
            add_key();
            draft.push_back(8'($urandom_range(kne_pkg::CH_ZERO, kne_pkg::CH_NINE)));
            commit_draft();
        end
        wait_drained();

        // Random phases, sender pausing for all results between them
        phase_no = 0;
        while (byte_count < ITEM_TARGET) begin
            program_key(phase_no);
            repeat ($urandom_range(8, 15)) make_buffer();
            wait_drained();
            phase_no++;
        end

        if (error_count == 0) begin
            $display("keyed_number_field_extractor_test OK");
        end else begin
            $display("keyed_number_field_extractor_test NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("keyed_number_field_extractor_test NOT OK");
        $finish;
    end

endmodule

@@ keyed_number_field_extractor.f @@
design/kne_pkg.sv
design/keyed_number_field_extractor.sv
dv/keyed_number_field_extractor_test.sv
